// ===== rtl/djsel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djsel_pkg
// Types, register map and constants of the dijet event selector.
// ----------------------------------------------------------------------------
package djsel_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_ETA_LIMIT        = 3'd0,
    REG_PT_LOW           = 3'd1,
    REG_PT_HIGH          = 3'd2,
    REG_PT_MODE          = 3'd3,
    REG_REQUIRE_OPPOSITE = 3'd4
  } djsel_reg_t;

  typedef enum logic [1:0] {
    PT_MODE_THRESH = 2'd0,
    PT_MODE_WINDOW = 2'd1,
    PT_MODE_MEAN   = 2'd2
  } djsel_pt_mode_t;

  localparam logic [10:0] ETA_LIMIT_RST = 11'd640;
  localparam logic [15:0] PT_LOW_RST    = 16'd640;
  localparam logic [15:0] PT_HIGH_RST   = 16'hFFFF;
  localparam logic [1:0]  PT_MODE_RST   = PT_MODE_THRESH;
  localparam logic        REQ_OPP_RST   = 1'b1;

  // |dphi - pi| < 1 rad holds exactly for |dphi| at or above this value
  localparam logic [11:0] PHI_OPP_MIN = 12'd1397;

  // magnitude of a 12-bit two's complement value, -2048 gives 2048
  function automatic logic [11:0] abs12(input logic [11:0] v);
    abs12 = v[11] ? (~v + 12'd1) : v;
  endfunction

endpackage

// ===== rtl/djsel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djsel_jet_if / djsel_res_if
// Valid/ready channels for jet items and event verdict items.
// ----------------------------------------------------------------------------
interface djsel_jet_if;
  logic               valid;
  logic               ready;
  logic        [15:0] jet_pt;
  logic signed [11:0] jet_eta;
  logic signed [11:0] jet_phi;
  logic               last_jet;

  modport source (output valid, jet_pt, jet_eta, jet_phi, last_jet, input ready);
  modport sink   (input valid, jet_pt, jet_eta, jet_phi, last_jet, output ready);
endinterface

interface djsel_res_if;
  logic valid;
  logic ready;
  logic accepted;
  logic two_found;

  modport source (output valid, accepted, two_found, input ready);
  modport sink   (input valid, accepted, two_found, output ready);
endinterface

// ===== rtl/dijet_event_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijet_event_selector
// Keeps the two highest-pt jets of an event and gives one verdict per event.
// ----------------------------------------------------------------------------
// a last jet's top pair is registered in the pair stage, then its verdict in the result register
// throughput: one jet per cycle while the input is not stalled; the top-two tracking compare runs once per jet
// input stalls only while the pair stage and the verdict register both hold an item
// reset: rst_n synchronous active low; clears tracking, pending verdicts,
// and loads the cut registers with their defaults
module dijet_event_selector (
  input  logic                           clk,
  input  logic                           rst_n,
  djsel_jet_if.sink                      in_jet,
  djsel_res_if.source                    out_res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [djsel_pkg::CFG_AW-1:0]   paddr,
  input  logic [djsel_pkg::CFG_DW-1:0]   pwdata,
  output logic [djsel_pkg::CFG_DW-1:0]   prdata,
  output logic                           pready
);

  // configuration
  logic [10:0] eta_limit_r;
  logic [15:0] pt_low_r;
  logic [15:0] pt_high_r;
  logic [1:0]  pt_mode_r;
  logic        require_opposite_r;

  djsel_pkg::djsel_reg_t reg_sel;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = djsel_pkg::djsel_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_limit_r        <= djsel_pkg::ETA_LIMIT_RST;
      pt_low_r           <= djsel_pkg::PT_LOW_RST;
      pt_high_r          <= djsel_pkg::PT_HIGH_RST;
      pt_mode_r          <= djsel_pkg::PT_MODE_RST;
      require_opposite_r <= djsel_pkg::REQ_OPP_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        djsel_pkg::REG_ETA_LIMIT:        eta_limit_r        <= pwdata[10:0];
        djsel_pkg::REG_PT_LOW:           pt_low_r           <= pwdata[15:0];
        djsel_pkg::REG_PT_HIGH:          pt_high_r          <= pwdata[15:0];
        djsel_pkg::REG_PT_MODE:          pt_mode_r          <= pwdata[1:0];
        djsel_pkg::REG_REQUIRE_OPPOSITE: require_opposite_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      djsel_pkg::REG_ETA_LIMIT:        prdata = {21'd0, eta_limit_r};
      djsel_pkg::REG_PT_LOW:           prdata = {16'd0, pt_low_r};
      djsel_pkg::REG_PT_HIGH:          prdata = {16'd0, pt_high_r};
      djsel_pkg::REG_PT_MODE:          prdata = {30'd0, pt_mode_r};
      djsel_pkg::REG_REQUIRE_OPPOSITE: prdata = {31'd0, require_opposite_r};
      default:                         prdata = '0;
    endcase
  end

  // handshakes
  logic out_free;
  logic p_fire;
  logic in_fire;

  logic p_valid_r, p_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_free     = !out_valid_r || out_res.ready;
  assign p_fire       = p_valid_r && out_free;
  assign in_jet.ready = !p_valid_r || out_free;
  assign in_fire      = in_jet.valid && in_jet.ready;

  // top-two tracking
  logic [15:0] lead_pt_r, lead_pt_nxt, second_pt_r, second_pt_nxt;
  logic [11:0] lead_eta_r, lead_eta_nxt, second_eta_r, second_eta_nxt;
  logic [11:0] lead_phi_r, lead_phi_nxt, second_phi_r, second_phi_nxt;
  logic [15:0] upd_lead_pt, upd_second_pt;
  logic [11:0] upd_lead_eta, upd_second_eta, upd_lead_phi, upd_second_phi;

  always_comb begin
    upd_lead_pt    = lead_pt_r;
    upd_lead_eta   = lead_eta_r;
    upd_lead_phi   = lead_phi_r;
    upd_second_pt  = second_pt_r;
    upd_second_eta = second_eta_r;
    upd_second_phi = second_phi_r;
    if (in_jet.jet_pt > lead_pt_r) begin
      upd_second_pt  = lead_pt_r;
      upd_second_eta = lead_eta_r;
      upd_second_phi = lead_phi_r;
      upd_lead_pt    = in_jet.jet_pt;
      upd_lead_eta   = in_jet.jet_eta;
      upd_lead_phi   = in_jet.jet_phi;
    end else if (in_jet.jet_pt > second_pt_r) begin
      upd_second_pt  = in_jet.jet_pt;
      upd_second_eta = in_jet.jet_eta;
      upd_second_phi = in_jet.jet_phi;
    end
  end

  always_comb begin
    lead_pt_nxt    = lead_pt_r;
    lead_eta_nxt   = lead_eta_r;
    lead_phi_nxt   = lead_phi_r;
    second_pt_nxt  = second_pt_r;
    second_eta_nxt = second_eta_r;
    second_phi_nxt = second_phi_r;
    if (in_fire) begin
      if (in_jet.last_jet) begin
        lead_pt_nxt    = '0;
        lead_eta_nxt   = '0;
        lead_phi_nxt   = '0;
        second_pt_nxt  = '0;
        second_eta_nxt = '0;
        second_phi_nxt = '0;
      end else begin
        lead_pt_nxt    = upd_lead_pt;
        lead_eta_nxt   = upd_lead_eta;
        lead_phi_nxt   = upd_lead_phi;
        second_pt_nxt  = upd_second_pt;
        second_eta_nxt = upd_second_eta;
        second_phi_nxt = upd_second_phi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pt_r    <= '0;
      lead_eta_r   <= '0;
      lead_phi_r   <= '0;
      second_pt_r  <= '0;
      second_eta_r <= '0;
      second_phi_r <= '0;
    end else begin
      lead_pt_r    <= lead_pt_nxt;
      lead_eta_r   <= lead_eta_nxt;
      lead_phi_r   <= lead_phi_nxt;
      second_pt_r  <= second_pt_nxt;
      second_eta_r <= second_eta_nxt;
      second_phi_r <= second_phi_nxt;
    end
  end

  // final pair of an event
  logic [15:0] p_lead_pt_r, p_second_pt_r;
  logic [11:0] p_lead_eta_r, p_second_eta_r, p_lead_phi_r, p_second_phi_r;

  always_comb begin
    p_valid_nxt = p_valid_r;
    if (in_fire && in_jet.last_jet) begin
      p_valid_nxt = 1'b1;
    end else if (p_fire) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_jet.last_jet) begin
      p_lead_pt_r    <= upd_lead_pt;
      p_lead_eta_r   <= upd_lead_eta;
      p_lead_phi_r   <= upd_lead_phi;
      p_second_pt_r  <= upd_second_pt;
      p_second_eta_r <= upd_second_eta;
      p_second_phi_r <= upd_second_phi;
    end
  end

  // verdict
  logic        two;
  logic        eta_ok;
  logic [16:0] pt_sum;
  logic        lead_in, second_in, win_mode;
  logic        pt_ok;
  logic [11:0] dphi;
  logic        opp_ok;
  logic        acc;

  assign two    = p_second_pt_r != 16'd0;
  assign eta_ok = (djsel_pkg::abs12(p_lead_eta_r) < {1'b0, eta_limit_r})
               && (djsel_pkg::abs12(p_second_eta_r) < {1'b0, eta_limit_r});
  assign pt_sum = {1'b0, p_lead_pt_r} + {1'b0, p_second_pt_r};
  assign win_mode  = pt_mode_r == djsel_pkg::PT_MODE_WINDOW;
  assign lead_in   = (p_lead_pt_r > pt_low_r) && (!win_mode || (p_lead_pt_r < pt_high_r));
  assign second_in = (p_second_pt_r > pt_low_r) && (!win_mode || (p_second_pt_r < pt_high_r));

  always_comb begin
    if (pt_mode_r == djsel_pkg::PT_MODE_MEAN) begin
      pt_ok = (pt_sum > {pt_low_r, 1'b0}) && (pt_sum < {pt_high_r, 1'b0});
    end else begin
      pt_ok = lead_in && second_in;
    end
  end

  // wrapped difference: a 12-bit difference is already phi modulo 2 pi
  assign dphi   = p_lead_phi_r - p_second_phi_r;
  assign opp_ok = djsel_pkg::abs12(dphi) >= djsel_pkg::PHI_OPP_MIN;
  assign acc    = two && eta_ok && pt_ok && (!require_opposite_r || opp_ok);

  // result register
  logic out_accepted_r, out_two_found_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (p_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (p_fire) begin
      out_accepted_r  <= acc;
      out_two_found_r <= two;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.accepted  = out_accepted_r;
  assign out_res.two_found = out_two_found_r;

  // checks
  a_top_order: assert property (@(posedge clk) disable iff (!rst_n)
    lead_pt_r >= second_pt_r)
    else $error("tracked second pt above lead pt");

  a_store_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_jet.last_jet |=> lead_pt_r == 16'd0 && second_pt_r == 16'd0)
    else $error("tracking store not cleared after last jet");

  a_pair_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(p_valid_r) |-> $past(in_fire && in_jet.last_jet))
    else $error("pair stage loaded without a last jet");

  a_acc_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_accepted_r |-> out_two_found_r)
    else $error("event accepted without two jets");

endmodule

// ===== tb/djsel_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// djsel_verdict_checker
// Watches the jet, verdict and register ports of the dijet event selector.
// Keeps its own copy of the cuts and of the top-two jet store, predicts the
// verdict of every event from the jets it sees accepted, and compares each
// verdict item with the oldest prediction.
// ----------------------------------------------------------------------------
module djsel_verdict_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            jet_valid,
  input  logic                            jet_ready,
  input  logic [15:0]                     jet_pt,
  input  logic signed [11:0]              jet_eta,
  input  logic signed [11:0]              jet_phi,
  input  logic                            last_jet,
  input  logic                            res_valid,
  input  logic                            res_ready,
  input  logic                            res_accepted,
  input  logic                            res_two_found,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [djsel_pkg::CFG_AW-1:0]    paddr,
  input  logic [djsel_pkg::CFG_DW-1:0]    pwdata,
  output int                              pending,
  output int                              fail_count
);

  typedef struct packed {
    logic accepted;
    logic two_found;
  } verdict_t;

  logic [10:0]        eta_lim;
  logic [15:0]        pt_lo;
  logic [15:0]        pt_hi;
  logic [1:0]         mode;
  logic               opp_req;

  logic [15:0]        lead_pt;
  logic signed [11:0] lead_eta;
  logic signed [11:0] lead_phi;
  logic [15:0]        sub_pt;
  logic signed [11:0] sub_eta;
  logic signed [11:0] sub_phi;

  verdict_t verdicts_due[$];

  function automatic int mag12(input logic signed [11:0] v);
    int s;
    s = v;
    return (s < 0) ? -s : s;
  endfunction

  // phi difference wrapped into (-pi, pi], far enough from zero
  function automatic bit back_to_back(input logic signed [11:0] a,
                                      input logic signed [11:0] b);
    int d;
    d = int'(a) - int'(b);
    if (d > 2048) d -= 4096;
    else if (d <= -2048) d += 4096;
    if (d < 0) d = -d;
    return d >= int'(djsel_pkg::PHI_OPP_MIN);
  endfunction

  function automatic verdict_t judge_event();
    verdict_t v;
    bit       pt_ok;
    bit       win;
    int       sum;
    v.two_found = (sub_pt != 16'd0);
    v.accepted  = 1'b0;
    if (v.two_found && mag12(lead_eta) < int'(eta_lim) && mag12(sub_eta) < int'(eta_lim)) begin
      if (mode == djsel_pkg::PT_MODE_MEAN) begin
        sum   = int'(lead_pt) + int'(sub_pt);
        pt_ok = (sum > 2 * int'(pt_lo)) && (sum < 2 * int'(pt_hi));
      end else begin
        win   = (mode == djsel_pkg::PT_MODE_WINDOW);
        pt_ok = (lead_pt > pt_lo) && (sub_pt > pt_lo) &&
                (!win || (lead_pt < pt_hi && sub_pt < pt_hi));
      end
      if (pt_ok) v.accepted = opp_req ? back_to_back(lead_phi, sub_phi) : 1'b1;
    end
    return v;
  endfunction

  function automatic void clear_store();
    lead_pt  = '0;
    lead_eta = '0;
    lead_phi = '0;
    sub_pt   = '0;
    sub_eta  = '0;
    sub_phi  = '0;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      eta_lim    = djsel_pkg::ETA_LIMIT_RST;
      pt_lo      = djsel_pkg::PT_LOW_RST;
      pt_hi      = djsel_pkg::PT_HIGH_RST;
      mode       = djsel_pkg::PT_MODE_RST;
      opp_req    = djsel_pkg::REQ_OPP_RST;
      fail_count = 0;
      clear_store();
      verdicts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[djsel_pkg::CFG_AW-1:2])
          djsel_pkg::REG_ETA_LIMIT:        eta_lim = pwdata[10:0];
          djsel_pkg::REG_PT_LOW:           pt_lo   = pwdata[15:0];
          djsel_pkg::REG_PT_HIGH:          pt_hi   = pwdata[15:0];
          djsel_pkg::REG_PT_MODE:          mode    = pwdata[1:0];
          djsel_pkg::REG_REQUIRE_OPPOSITE: opp_req = pwdata[0];
          default: ;
        endcase
      end

      if (res_valid && res_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict item with no event pending: accepted=%0b two_found=%0b",
                 res_accepted, res_two_found);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          if (res_accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, res_accepted);
            fail_count++;
          end
          if (res_two_found !== want.two_found) begin
            $error("two_found: expected %0b, got %0b", want.two_found, res_two_found);
            fail_count++;
          end
        end
      end

      if (jet_valid && jet_ready) begin
        if (jet_pt > lead_pt) begin
          sub_pt   = lead_pt;
          sub_eta  = lead_eta;
          sub_phi  = lead_phi;
          lead_pt  = jet_pt;
          lead_eta = jet_eta;
          lead_phi = jet_phi;
        end else if (jet_pt > sub_pt) begin
          sub_pt  = jet_pt;
          sub_eta = jet_eta;
          sub_phi = jet_phi;
        end
        if (last_jet) begin
          verdicts_due = {verdicts_due, judge_event()};
          clear_store();
        end
      end
    end
    pending <= verdicts_due.size();
  end

endmodule

// ===== tb/dijet_event_selector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijet_event_selector_tb
// Drives jet events and cut settings into the dijet event selector. A short
// directed set hits the corners, then random events run under a series of
// cut settings with random gaps and stalls on both channels. The checker
// beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module dijet_event_selector_tb;

  localparam int         LIMIT          = 300000;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         PHASE_JETS     = 200;
  localparam int         PHASES         = 8;
  localparam logic [2:0] REG_UNMAPPED   = 3'(djsel_pkg::REG_REQUIRE_OPPOSITE) + 3'd1;
  localparam logic [1:0] PT_MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [djsel_pkg::CFG_AW-1:0] paddr;
  logic [djsel_pkg::CFG_DW-1:0] pwdata;
  logic [djsel_pkg::CFG_DW-1:0] prdata;
  logic                         pready;

  djsel_jet_if jet_ch ();
  djsel_res_if res_ch ();

  int verdicts_pending;
  int mismatches;
  int cycle_cnt = 0;
  int jets_sent = 0;
  int hold_req  = 0;
  int hold_ack  = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  int cur_eta_lim;
  int cur_pt_lo;
  int cur_pt_hi;

  dijet_event_selector dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_jet  (jet_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  djsel_verdict_checker verdict_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .jet_valid     (jet_ch.valid),
    .jet_ready     (jet_ch.ready),
    .jet_pt        (jet_ch.jet_pt),
    .jet_eta       (jet_ch.jet_eta),
    .jet_phi       (jet_ch.jet_phi),
    .last_jet      (jet_ch.last_jet),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_accepted  (res_ch.accepted),
    .res_two_found (res_ch.two_found),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pending       (verdicts_pending),
    .fail_count    (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // verdict receiver, with long hold-offs on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ack != hold_req) begin
        hold_ack = hold_req;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(99) < 29) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input int unsigned val,
                           input int width);
    logic [31:0] mask;
    mask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom() & ~mask) | (val & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_cuts(input int eta_l, input int pt_l, input int pt_h,
                          input logic [1:0] mode, input logic opp);
    reg_write(djsel_pkg::REG_ETA_LIMIT, eta_l, 11);
    reg_write(djsel_pkg::REG_PT_LOW, pt_l, 16);
    reg_write(djsel_pkg::REG_PT_HIGH, pt_h, 16);
    reg_write(djsel_pkg::REG_PT_MODE, mode, 2);
    reg_write(djsel_pkg::REG_REQUIRE_OPPOSITE, opp, 1);
    cur_eta_lim = eta_l & 11'h7FF;
    cur_pt_lo   = pt_l & 16'hFFFF;
    cur_pt_hi   = pt_h & 16'hFFFF;
  endtask

  task automatic send_jet(input logic [15:0] pt, input logic signed [11:0] eta,
                          input logic signed [11:0] phi, input logic last);
    if (tx_idle_on) begin
      while ($urandom_range(99) < 29) begin
        jet_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    jet_ch.valid    <= 1'b1;
    jet_ch.jet_pt   <= pt;
    jet_ch.jet_eta  <= eta;
    jet_ch.jet_phi  <= phi;
    jet_ch.last_jet <= last;
    @(posedge clk);
    while (!jet_ch.ready) @(posedge clk);
    jets_sent++;
  endtask

  // sender stops until every verdict is in, then lets the pipeline settle
  task automatic drain();
    jet_ch.valid <= 1'b0;
    @(posedge clk);
    wait (verdicts_pending == 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pt();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 8) v = 0;
    else if (r < 14) v = 65535;
    else if (r < 28) v = cur_pt_lo + int'($urandom_range(2)) - 1;
    else if (r < 38) v = cur_pt_hi + int'($urandom_range(2)) - 1;
    else if (r < 78 && cur_pt_hi > cur_pt_lo + 1)
      v = int'($urandom_range(cur_pt_hi - 1, cur_pt_lo + 1));
    else v = int'($urandom_range(65535));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic signed [11:0] pick_eta();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 60) begin
      if (cur_eta_lim == 0) v = 0;
      else v = int'($urandom_range(2 * cur_eta_lim - 2)) - (cur_eta_lim - 1);
    end else if (r < 78) begin
      v = cur_eta_lim - int'($urandom_range(1));
      if (r[0]) v = -v;
    end else begin
      v = int'($urandom_range(4095)) - 2048;
    end
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v[11:0];
  endfunction

  // mostly near the opposite side of the previous jet, wrapping freely
  function automatic logic signed [11:0] pick_phi(input logic signed [11:0] prev);
    int v;
    if ($urandom_range(99) < 55)
      v = int'(prev) + 2048 + int'($urandom_range(1400)) - 700;
    else
      v = int'($urandom_range(4095));
    return v[11:0];
  endfunction

  task automatic random_event();
    int                 n;
    logic signed [11:0] phi;
    n   = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 4);
    phi = 12'($urandom_range(4095));
    for (int i = 0; i < n; i++) begin
      phi = pick_phi(phi);
      send_jet(pick_pt(), pick_eta(), phi, i == n - 1);
    end
  endtask

  initial begin
    int phase_goal;
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    jet_ch.valid    <= 1'b0;
    jet_ch.jet_pt   <= '0;
    jet_ch.jet_eta  <= '0;
    jet_ch.jet_phi  <= '0;
    jet_ch.last_jet <= 1'b0;
    cur_eta_lim = djsel_pkg::ETA_LIMIT_RST;
    cur_pt_lo   = djsel_pkg::PT_LOW_RST;
    cur_pt_hi   = djsel_pkg::PT_HIGH_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // corners under the reset cuts
    send_jet(16'd1000, 0, 0, 1'b1);
    send_jet(16'd0, 100, 500, 1'b0);
    send_jet(16'd0, -100, -500, 1'b1);
    send_jet(16'hFFFF, 0, 0, 1'b0);
    send_jet(16'hFFFF, -1, -2048, 1'b1);
    send_jet(16'd2000, 639, 2047, 1'b0);
    send_jet(16'd3000, -639, -1, 1'b1);
    send_jet(16'd5000, -2048, 0, 1'b0);
    send_jet(16'd6000, 2047, 1397, 1'b1);
    send_jet(16'd5000, 0, 0, 1'b0);
    send_jet(16'd4000, 0, 1397, 1'b1);
    send_jet(16'd5000, 0, 0, 1'b0);
    send_jet(16'd4000, 0, -1396, 1'b1);
    send_jet(16'd1000, 10, -300, 1'b0);
    send_jet(16'd3000, -10, 1800, 1'b0);
    send_jet(16'd2000, 20, -200, 1'b0);
    send_jet(16'd700, 0, 0, 1'b1);
    send_jet(16'd640, 0, 0, 1'b0);
    send_jet(16'd641, 0, -2048, 1'b1);
    send_jet(16'd9000, 640, 0, 1'b0);
    send_jet(16'd8000, -5, -2048, 1'b1);

    phase_goal = jets_sent;
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      case (ph)
        0: set_cuts(2047, 0, 65535, djsel_pkg::PT_MODE_THRESH, 1'b0);
        1: set_cuts(0, 65535, 0, djsel_pkg::PT_MODE_WINDOW, 1'b1);
        2: set_cuts(1024, $urandom_range(4000), 20000 + $urandom_range(20000),
                    djsel_pkg::PT_MODE_MEAN, 1'b1);
        3: begin
          reg_write(REG_UNMAPPED, $urandom(), 32);
          set_cuts(900, 2000, $urandom_range(3000), PT_MODE_UNUSED, 1'b0);
        end
        4: set_cuts(700, $urandom_range(8000), $urandom_range(1000),
                    djsel_pkg::PT_MODE_THRESH, 1'b1);
        5: begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
          set_cuts(1500, 1000, 50000, djsel_pkg::PT_MODE_WINDOW, 1'b1);
        end
        default: begin
          cur_pt_lo = $urandom_range(30000);
          set_cuts($urandom_range(2047), cur_pt_lo, cur_pt_lo + $urandom_range(35000),
                   2'($urandom_range(3)), 1'($urandom_range(1)));
        end
      endcase
      if (ph == 2) begin
        // receiver holds off while short events pile up behind it
        hold_req++;
        for (int i = 0; i < 60; i++) send_jet(pick_pt(), pick_eta(), 12'($urandom()), 1'b1);
      end
      phase_goal += PHASE_JETS;
      while (jets_sent < phase_goal) random_event();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
